// ===== rtl/core/gbsm_pkg.sv =====
// Shared constants, types, map tables and arithmetic helpers for the gimbal servo map.
`default_nettype none

package gbsm_pkg;

  localparam int ANGLE_FRAC_BITS = 8;

  // port widths
  localparam int SP_W      = 16;
  localparam int OFS_W     = 16;
  localparam int RAW_W     = 15;
  localparam int CMD_W     = 7;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_OFFSET   = 1'b1;

  localparam logic [OFS_W-1:0] PITCH_OFFSET_RST = 16'd23040;
  localparam logic [OFS_W-1:0] YAW_OFFSET_RST   = 16'd22784;

  // grid geometry
  localparam int GRID_N    = 9;
  localparam int MAP_CELLS = GRID_N * GRID_N;
  localparam int CELL_MAX  = 7;
  localparam int IDX_W     = 3;
  localparam int AW        = $clog2(MAP_CELLS);
  localparam int LIM_DEG   = 20;
  localparam int STEP_DEG  = 5;
  localparam int LIM       = LIM_DEG << ANGLE_FRAC_BITS;
  localparam int STEP      = STEP_DEG << ANGLE_FRAC_BITS;

  // internal widths
  localparam int ROM_W   = ANGLE_FRAC_BITS + 7;  // |entry| < 64 deg, signed
  localparam int U_W     = ANGLE_FRAC_BITS + 6;  // shifted setpoint 0..40 deg
  localparam int WHOLE_W = 6;
  localparam int REM_W   = ANGLE_FRAC_BITS + 3;  // remainder 0..5 deg
  localparam int FR_W    = ANGLE_FRAC_BITS + 1;  // fraction 0..1.0
  localparam int DIV_K   = REM_W + 3;
  localparam int DIV_M   = ((2 ** DIV_K) + STEP_DEG - 1) / STEP_DEG;
  localparam int DIVP_W  = REM_W + DIV_K;
  localparam int LP_W    = ROM_W + FR_W + 2;
  localparam int SUM_W   = ((ROM_W > OFS_W + 1) ? ROM_W : OFS_W + 1) + 1;

  localparam int CMD_MIN = 60;
  localparam int CMD_MAX = 120;
  localparam int RAW_MAX = (2 ** (RAW_W - 1)) - 1;
  localparam int RAW_MIN = -(2 ** (RAW_W - 1));

  typedef logic signed [ROM_W-1:0] rom_t;
  typedef logic [FR_W-1:0]         frac_t;

  // map entries in millionths of a degree, [yaw row][pitch column] row-major
  localparam int TOP_MICRO [MAP_CELLS] = '{
    -1306221,   5164407,  11298533,  17210218,  23018482,  28964504,  35107468,  41307199,
    47574315,
    -6744026,   -423434,   5579505,  11364200,  16952160,  23106720,  29067197,  35066980,
    41111088,
    -12117680, -5909759,         0,   5711151,  11170965,  17252006,  23077774,  28932407,
    34818812,
    -17492678, -11368308, -5512334,    155048,   5554293,  11437110,  17176252,  22937908,
    28724942,
    -23018482, -16753008, -10928924, -5272502,         0,   5272502,  10928924,  16753008,
    23018482,
    -28724942, -22937908, -17176252, -11437110, -5554293,   -155048,   5512334,  11368308,
    17492678,
    -34818812, -28932407, -23077774, -17252006, -11170965, -5711151,         0,   5909759,
    12117680,
    -41111088, -35066980, -29067197, -23106720, -16952160, -11364200, -5579505,    423434,
    6744026,
    -47574315, -41307199, -35107468, -28964504, -23018482, -17210218, -11298533, -5164407,
    1306221
  };

  localparam int BOT_MICRO [MAP_CELLS] = '{
    -42129333, -36747015, -31198556, -25576657, -20467741, -15181597,  -9390883,  -3672455,
    2003914,
    -37334843, -32062079, -26586062, -21008485, -15836313,  -9940778,  -4361664,   1184972,
    6715591,
    -31979404, -26824999, -21443005, -15937261, -10753458,  -4804774,    643552,   6080286,
    11513122,
    -26390838, -21336456, -16038791, -10598426,  -5420747,    306039,   5683913,  11059438,
    16433658,
    -21364376, -16268496, -10949558,  -5498094,         0,   5498094,  10949558,  16268496,
    21364376,
    -16433658, -11059438,  -5683913,   -306039,   5420747,  10598426,  16038791,  21336456,
    26390838,
    -11513122,  -6080286,   -643552,   4804774,  10753458,  15937261,  21443005,  26824999,
    31979404,
    -6715591,   -1184972,   4361664,   9940778,  15836313,  21008485,  26586062,  32062079,
    37334843,
    -2003914,    3672455,   9390883,  15181597,  20467741,  25576657,  31198556,  36747015,
    42129333
  };

  // micro-degrees to fixed point, round half away from zero (elaboration only)
  function automatic rom_t rom_fixed(input int micro);
    longint m;
    longint a;
    longint q;
    m = longint'(micro);
    a = (m < 0) ? -m : m;
    q = ((a << ANGLE_FRAC_BITS) + 64'sd500000) / 64'sd1000000;
    return (m < 0) ? rom_t'(-q) : rom_t'(q);
  endfunction

  // clamp to +/-20 deg and shift to 0..40 deg
  function automatic logic [U_W-1:0] clamp_shift(input logic signed [SP_W-1:0] sp);
    int v;
    v = int'(sp);
    if (v < -LIM) begin
      v = -LIM;
    end else if (v > LIM) begin
      v = LIM;
    end
    return U_W'(v + LIM);
  endfunction

  // q0 + trunc(f * (q1 - q0)), truncation toward zero
  function automatic rom_t lerp(input rom_t q0, input rom_t q1, input frac_t f);
    logic signed [ROM_W:0]   d;
    logic signed [LP_W-1:0]  p;
    logic signed [LP_W-1:0]  t;
    d = (ROM_W + 1)'(q1) - (ROM_W + 1)'(q0);
    p = LP_W'(d) * LP_W'($signed({1'b0, f}));
    t = p[LP_W-1] ? -((-p) >>> ANGLE_FRAC_BITS) : (p >>> ANGLE_FRAC_BITS);
    return rom_t'(LP_W'(q0) + t);
  endfunction

  // whole degrees, truncated toward zero, saturated to the servo range
  function automatic logic [CMD_W-1:0] to_cmd(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] d;
    d = s[SUM_W-1] ? -((-s) >>> ANGLE_FRAC_BITS) : (s >>> ANGLE_FRAC_BITS);
    if (d < CMD_MIN) begin
      return CMD_W'(CMD_MIN);
    end else if (d > CMD_MAX) begin
      return CMD_W'(CMD_MAX);
    end
    return CMD_W'(d);
  endfunction

  function automatic logic [RAW_W-1:0] raw_sat(input rom_t v);
    if (v < RAW_MIN) begin
      return RAW_W'(RAW_MIN);
    end else if (v > RAW_MAX) begin
      return RAW_W'(RAW_MAX);
    end
    return RAW_W'(v);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gimbal_bilinear_servo_map.sv =====
// Gimbal servo map: six-stage bilinear lookup of top and bottom servo angles.
// A word taken with start passes registers S1 to S6 and then shows on the out_ ports
//   (out_valid high for one cycle). Throughput: one word per clock; every stage takes a
//   new word each cycle and no multiplier or table port is shared between words.
// busy is high in reset and stays high until a clock edge samples rst_n high, low from
//   then on, so start is otherwise never refused; results cannot be held off.
// Reset (rst_n low, synchronous): all stage valids clear, offsets return to defaults.
`default_nettype none

module gimbal_bilinear_servo_map (
  input  wire                                      clk,
  input  wire                                      rst_n,
  // setpoint word
  input  wire                                      start,
  output logic                                     busy,
  input  wire  signed [gbsm_pkg::SP_W-1:0]         in_pitch_setpoint,
  input  wire  signed [gbsm_pkg::SP_W-1:0]         in_yaw_setpoint,
  // result word
  output logic                                     out_valid,
  output logic signed [gbsm_pkg::RAW_W-1:0]        out_top_angle_raw,
  output logic signed [gbsm_pkg::RAW_W-1:0]        out_bottom_angle_raw,
  output logic        [gbsm_pkg::CMD_W-1:0]        out_top_servo_cmd,
  output logic        [gbsm_pkg::CMD_W-1:0]        out_bottom_servo_cmd,
  // register writes
  input  wire                                      cfg_valid,
  output logic                                     cfg_ready,
  input  wire         [gbsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire         [gbsm_pkg::OFS_W-1:0]        cfg_data
);

  import gbsm_pkg::*;

  // ---------------------------------------------------------------------------
  // Constant map tables, fixed point, built at elaboration
  // ---------------------------------------------------------------------------
  rom_t top_rom [MAP_CELLS];
  rom_t bot_rom [MAP_CELLS];

  for (genvar g = 0; g < MAP_CELLS; g++) begin : g_rom
    localparam rom_t TOP_Q = rom_fixed(TOP_MICRO[g]);
    localparam rom_t BOT_Q = rom_fixed(BOT_MICRO[g]);
    assign top_rom[g] = TOP_Q;
    assign bot_rom[g] = BOT_Q;
  end

  // ---------------------------------------------------------------------------
  // Control: always ready once out of reset
  // ---------------------------------------------------------------------------
  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    busy_r <= ~rst_n;
  end

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy_r;

  // ---------------------------------------------------------------------------
  // Offset registers
  // ---------------------------------------------------------------------------
  logic [OFS_W-1:0] pitch_ofs_r;
  logic [OFS_W-1:0] yaw_ofs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_ofs_r <= PITCH_OFFSET_RST;
      yaw_ofs_r   <= YAW_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PITCH_OFFSET: pitch_ofs_r <= cfg_data;
        REG_YAW_OFFSET:   yaw_ofs_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage valids
  // ---------------------------------------------------------------------------
  logic [5:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], accept};
    end
  end

  // ---------------------------------------------------------------------------
  // S1: clamp to +/-20 deg, shift to 0..40 deg
  // ---------------------------------------------------------------------------
  logic [U_W-1:0] s1_pu_r, s1_yu_r;

  always_ff @(posedge clk) begin
    s1_pu_r <= clamp_shift(in_pitch_setpoint);
    s1_yu_r <= clamp_shift(in_yaw_setpoint);
  end

  // ---------------------------------------------------------------------------
  // S2: cell index (clamped to 7), remainder inside cell, map address
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] col_nxt, row_nxt;
  logic [REM_W-1:0] s2_prem_r, s2_yrem_r;
  logic [AW-1:0]    s2_base_r;

  always_comb begin
    col_nxt = '0;
    row_nxt = '0;
    for (int k = 1; k <= CELL_MAX; k++) begin
      if (s1_pu_r[U_W-1 -: WHOLE_W] >= WHOLE_W'(STEP_DEG * k)) col_nxt = IDX_W'(k);
      if (s1_yu_r[U_W-1 -: WHOLE_W] >= WHOLE_W'(STEP_DEG * k)) row_nxt = IDX_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    s2_prem_r <= REM_W'(s1_pu_r - U_W'(int'(col_nxt) * STEP));
    s2_yrem_r <= REM_W'(s1_yu_r - U_W'(int'(row_nxt) * STEP));
    s2_base_r <= AW'(int'(row_nxt) * GRID_N + int'(col_nxt));
  end

  // ---------------------------------------------------------------------------
  // S3: fraction = remainder / 5 by reciprocal multiply; read four corners
  // ---------------------------------------------------------------------------
  logic [DIVP_W-1:0] pdiv, ydiv;
  frac_t             s3_pf_r, s3_yf_r;
  rom_t              s3_t11_r, s3_t12_r, s3_t21_r, s3_t22_r;
  rom_t              s3_b11_r, s3_b12_r, s3_b21_r, s3_b22_r;

  assign pdiv = DIVP_W'(s2_prem_r) * DIVP_W'(DIV_M);
  assign ydiv = DIVP_W'(s2_yrem_r) * DIVP_W'(DIV_M);

  always_ff @(posedge clk) begin
    s3_pf_r  <= FR_W'(pdiv >> DIV_K);
    s3_yf_r  <= FR_W'(ydiv >> DIV_K);
    s3_t11_r <= top_rom[s2_base_r];
    s3_t12_r <= top_rom[AW'(s2_base_r + AW'(1))];
    s3_t21_r <= top_rom[AW'(s2_base_r + AW'(GRID_N))];
    s3_t22_r <= top_rom[AW'(s2_base_r + AW'(GRID_N + 1))];
    s3_b11_r <= bot_rom[s2_base_r];
    s3_b12_r <= bot_rom[AW'(s2_base_r + AW'(1))];
    s3_b21_r <= bot_rom[AW'(s2_base_r + AW'(GRID_N))];
    s3_b22_r <= bot_rom[AW'(s2_base_r + AW'(GRID_N + 1))];
  end

  // ---------------------------------------------------------------------------
  // S4: interpolate along pitch on both rows of the cell
  // ---------------------------------------------------------------------------
  rom_t  s4_ta_r, s4_tb_r, s4_ba_r, s4_bb_r;
  frac_t s4_yf_r;

  always_ff @(posedge clk) begin
    s4_ta_r <= lerp(s3_t11_r, s3_t12_r, s3_pf_r);
    s4_tb_r <= lerp(s3_t21_r, s3_t22_r, s3_pf_r);
    s4_ba_r <= lerp(s3_b11_r, s3_b12_r, s3_pf_r);
    s4_bb_r <= lerp(s3_b21_r, s3_b22_r, s3_pf_r);
    s4_yf_r <= s3_yf_r;
  end

  // ---------------------------------------------------------------------------
  // S5: interpolate along yaw
  // ---------------------------------------------------------------------------
  rom_t s5_top_r, s5_bot_r;

  always_ff @(posedge clk) begin
    s5_top_r <= lerp(s4_ta_r, s4_tb_r, s4_yf_r);
    s5_bot_r <= lerp(s4_ba_r, s4_bb_r, s4_yf_r);
  end

  // ---------------------------------------------------------------------------
  // S6: raw saturation, offsets, whole-degree commands
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] top_sum, bot_sum;

  assign top_sum = SUM_W'(s5_top_r) + SUM_W'($signed({1'b0, pitch_ofs_r}));
  assign bot_sum = SUM_W'($signed({1'b0, yaw_ofs_r})) - SUM_W'(s5_bot_r);

  logic signed [RAW_W-1:0] out_top_raw_r, out_bot_raw_r;
  logic [CMD_W-1:0]        out_top_cmd_r, out_bot_cmd_r;

  always_ff @(posedge clk) begin
    out_top_raw_r <= raw_sat(s5_top_r);
    out_bot_raw_r <= raw_sat(s5_bot_r);
    out_top_cmd_r <= to_cmd(top_sum);
    out_bot_cmd_r <= to_cmd(bot_sum);
  end

  assign out_valid            = vld_r[5];
  assign out_top_angle_raw    = out_top_raw_r;
  assign out_bottom_angle_raw = out_bot_raw_r;
  assign out_top_servo_cmd    = out_top_cmd_r;
  assign out_bottom_servo_cmd = out_bot_cmd_r;

endmodule

`default_nettype wire

// ===== tb/gbsm_tb_pkg.sv =====
// Scoreboard for the gimbal servo map: fixed-point predictor and queue of expected result words.
package gbsm_tb_pkg;

  localparam int     FRAC_BITS  = 8;
  localparam int     GRID       = 9;
  localparam int     LAST_CELL  = 7;
  localparam longint LIM_FX     = 20 * (1 << FRAC_BITS);
  localparam longint STEP_FX    = 5 * (1 << FRAC_BITS);
  localparam int     SERVO_LOW  = 60;
  localparam int     SERVO_HIGH = 120;
  localparam longint RAW_TOP    = 16383;
  localparam longint RAW_BOTTOM = -16384;

  typedef logic signed [gbsm_pkg::SP_W-1:0]  setpoint_t;
  typedef logic        [gbsm_pkg::OFS_W-1:0] offset_t;
  typedef logic [gbsm_pkg::CFG_IDX_W-1:0]    reg_index_t;

  localparam offset_t PITCH_OFS_RESET = 16'd23040;
  localparam offset_t YAW_OFS_RESET   = 16'd22784;

  typedef struct packed {
    logic signed [gbsm_pkg::RAW_W-1:0] top_raw;
    logic signed [gbsm_pkg::RAW_W-1:0] bot_raw;
    logic        [gbsm_pkg::CMD_W-1:0] top_cmd;
    logic        [gbsm_pkg::CMD_W-1:0] bot_cmd;
  } servo_word_t;

  // micro-degrees, [yaw row][pitch column], row-major
  localparam int TOP_MAP_U [GRID*GRID] = '{
    -1306221,   5164407,  11298533,  17210218,  23018482,  28964504,  35107468,  41307199,
    47574315,
    -6744026,   -423434,   5579505,  11364200,  16952160,  23106720,  29067197,  35066980,
    41111088,
    -12117680, -5909759,         0,   5711151,  11170965,  17252006,  23077774,  28932407,
    34818812,
    -17492678, -11368308, -5512334,    155048,   5554293,  11437110,  17176252,  22937908,
    28724942,
    -23018482, -16753008, -10928924, -5272502,         0,   5272502,  10928924,  16753008,
    23018482,
    -28724942, -22937908, -17176252, -11437110, -5554293,   -155048,   5512334,  11368308,
    17492678,
    -34818812, -28932407, -23077774, -17252006, -11170965, -5711151,         0,   5909759,
    12117680,
    -41111088, -35066980, -29067197, -23106720, -16952160, -11364200, -5579505,    423434,
    6744026,
    -47574315, -41307199, -35107468, -28964504, -23018482, -17210218, -11298533, -5164407,
    1306221
  };

  localparam int BOT_MAP_U [GRID*GRID] = '{
    -42129333, -36747015, -31198556, -25576657, -20467741, -15181597,  -9390883,  -3672455,
    2003914,
    -37334843, -32062079, -26586062, -21008485, -15836313,  -9940778,  -4361664,   1184972,
    6715591,
    -31979404, -26824999, -21443005, -15937261, -10753458,  -4804774,    643552,   6080286,
    11513122,
    -26390838, -21336456, -16038791, -10598426,  -5420747,    306039,   5683913,  11059438,
    16433658,
    -21364376, -16268496, -10949558,  -5498094,         0,   5498094,  10949558,  16268496,
    21364376,
    -16433658, -11059438,  -5683913,   -306039,   5420747,  10598426,  16038791,  21336456,
    26390838,
    -11513122,  -6080286,   -643552,   4804774,  10753458,  15937261,  21443005,  26824999,
    31979404,
    -6715591,   -1184972,   4361664,   9940778,  15836313,  21008485,  26586062,  32062079,
    37334843,
    -2003914,    3672455,   9390883,  15181597,  20467741,  25576657,  31198556,  36747015,
    42129333
  };

  class servo_map_scoreboard;
    servo_word_t expected_q[$];
    offset_t     pitch_ofs;
    offset_t     yaw_ofs;
    int unsigned mismatches;
    int unsigned stray_words;
    int unsigned reported;

    function new();
      pitch_ofs   = PITCH_OFS_RESET;
      yaw_ofs     = YAW_OFS_RESET;
      mismatches  = 0;
      stray_words = 0;
      reported    = 0;
    endfunction

    function void set_offset(reg_index_t idx, offset_t val);
      if (idx == gbsm_pkg::REG_PITCH_OFFSET) begin
        pitch_ofs = val;
      end else if (idx == gbsm_pkg::REG_YAW_OFFSET) begin
        yaw_ofs = val;
      end
    endfunction

    // round half away from zero
    function longint to_fixed(int micro);
      longint a;
      longint q;
      a = (micro < 0) ? -longint'(micro) : longint'(micro);
      q = ((a << FRAC_BITS) + 500000) / 1000000;
      return (micro < 0) ? -q : q;
    endfunction

    function longint trunc_shift(longint p);
      return (p >= 0) ? (p >>> FRAC_BITS) : -((-p) >>> FRAC_BITS);
    endfunction

    function void find_cell(setpoint_t sp, output int idx, output longint frac);
      longint v;
      longint u;
      longint i;
      v = longint'(sp);
      if (v < -LIM_FX) v = -LIM_FX;
      if (v > LIM_FX) v = LIM_FX;
      u = v + LIM_FX;
      i = u / STEP_FX;
      if (i > LAST_CELL) i = LAST_CELL;
      idx  = int'(i);
      frac = (u - i * STEP_FX) / 5;
    endfunction

    function longint map_at(bit top_map, int row, int col);
      return to_fixed(top_map ? TOP_MAP_U[row*GRID + col] : BOT_MAP_U[row*GRID + col]);
    endfunction

    // along pitch first, then along yaw
    function longint blend(bit top_map, int row, int col, longint pf, longint yf);
      longint q11;
      longint q12;
      longint q21;
      longint q22;
      longint a;
      longint b;
      q11 = map_at(top_map, row, col);
      q12 = map_at(top_map, row, col + 1);
      q21 = map_at(top_map, row + 1, col);
      q22 = map_at(top_map, row + 1, col + 1);
      a = q11 + trunc_shift(pf * (q12 - q11));
      b = q21 + trunc_shift(pf * (q22 - q21));
      return a + trunc_shift(yf * (b - a));
    endfunction

    function logic [gbsm_pkg::CMD_W-1:0] servo_cmd(longint s);
      longint d;
      d = trunc_shift(s);
      if (d < SERVO_LOW) d = SERVO_LOW;
      if (d > SERVO_HIGH) d = SERVO_HIGH;
      return gbsm_pkg::CMD_W'(d);
    endfunction

    function logic [gbsm_pkg::RAW_W-1:0] raw_clip(longint v);
      if (v < RAW_BOTTOM) v = RAW_BOTTOM;
      if (v > RAW_TOP) v = RAW_TOP;
      return gbsm_pkg::RAW_W'(v);
    endfunction

    function void note_setpoint(setpoint_t pitch, setpoint_t yaw);
      int          col;
      int          row;
      longint      pf;
      longint      yf;
      longint      top;
      longint      bot;
      servo_word_t w;
      find_cell(pitch, col, pf);
      find_cell(yaw, row, yf);
      top = blend(1'b1, row, col, pf, yf);
      bot = blend(1'b0, row, col, pf, yf);
      w.top_raw = raw_clip(top);
      w.bot_raw = raw_clip(bot);
      w.top_cmd = servo_cmd(top + longint'(pitch_ofs));
      w.bot_cmd = servo_cmd(longint'(yaw_ofs) - bot);
      expected_q.push_back(w);
    endfunction

    function void check_result(servo_word_t got);
      servo_word_t w;
      if (expected_q.size() == 0) begin
        stray_words++;
        reported++;
        if (reported <= 10) begin
          $display("unexpected word: top_raw %0d bot_raw %0d top_cmd %0d bot_cmd %0d",
                   got.top_raw, got.bot_raw, got.top_cmd, got.bot_cmd);
        end
        return;
      end
      w = expected_q.pop_front();
      if (got.top_raw !== w.top_raw || got.bot_raw !== w.bot_raw ||
          got.top_cmd !== w.top_cmd || got.bot_cmd !== w.bot_cmd) begin
        mismatches++;
        reported++;
        if (reported <= 10) begin
          $display("mismatch: top_raw %0d/%0d bot_raw %0d/%0d top_cmd %0d/%0d bot_cmd %0d/%0d",
                   w.top_raw, got.top_raw, w.bot_raw, got.bot_raw,
                   w.top_cmd, got.top_cmd, w.bot_cmd, got.bot_cmd);
        end
      end
    endfunction

    function int unsigned failures();
      return mismatches + stray_words + expected_q.size();
    endfunction
  endclass

endpackage

// ===== tb/gimbal_bilinear_servo_map_tb.sv =====
// Self-checking testbench for the gimbal servo map: directed and random setpoints under offset changes.
module gimbal_bilinear_servo_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbsm_tb_pkg::*;

  localparam int STALL_LIMIT     = 1000;  // cycles with no word moving on any port
  localparam int DRAIN_TAIL      = 8;     // pipeline is six deep; a little slack on top
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 106;
  localparam int N_DIRECTED      = 20;

  // directed setpoints: grid corners, the +/-20 limits, clamping from far outside,
  // cell boundaries and points just either side of them, alternating bit patterns
  localparam setpoint_t DIR_PITCH [N_DIRECTED] = '{
    16'sd0,     16'sd5120,  -16'sd5120, 16'sd5120,  -16'sd5120,
    16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd5121,
    16'sd5119,  16'sd1280,  16'sd1279,  16'sd3839,  -16'sd1,
    -16'sd3840, 16'sd2560,  16'sd0,     16'sd21845, -16'sd21846
  };
  localparam setpoint_t DIR_YAW [N_DIRECTED] = '{
    16'sd0,     16'sd5120,  -16'sd5120, -16'sd5120, 16'sd5120,
    16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd5121,
    -16'sd5119, -16'sd1280, 16'sd2561,  16'sd3840,  16'sd1,
    -16'sd2560, 16'sd0,     16'sd2560,  -16'sd21846, 16'sd21845
  };

  logic       clk   = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  setpoint_t  in_pitch_setpoint = '0;
  setpoint_t  in_yaw_setpoint   = '0;
  logic       cfg_valid = 1'b0;
  reg_index_t cfg_index = gbsm_pkg::REG_PITCH_OFFSET;
  offset_t    cfg_data  = '0;

  wire                               busy;
  wire                               out_valid;
  wire signed [gbsm_pkg::RAW_W-1:0]  out_top_angle_raw;
  wire signed [gbsm_pkg::RAW_W-1:0]  out_bottom_angle_raw;
  wire        [gbsm_pkg::CMD_W-1:0]  out_top_servo_cmd;
  wire        [gbsm_pkg::CMD_W-1:0]  out_bottom_servo_cmd;
  wire                               cfg_ready;

  servo_map_scoreboard sb;
  servo_word_t         seen;
  int unsigned         idle_cycles = 0;

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gimbal_bilinear_servo_map uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_pitch_setpoint    (in_pitch_setpoint),
    .in_yaw_setpoint      (in_yaw_setpoint),
    .out_valid            (out_valid),
    .out_top_angle_raw    (out_top_angle_raw),
    .out_bottom_angle_raw (out_bottom_angle_raw),
    .out_top_servo_cmd    (out_top_servo_cmd),
    .out_bottom_servo_cmd (out_bottom_servo_cmd),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // Result words are sampled mid-cycle; inputs only move at the rising edge, so the
  // strobe and its payload are settled here and each strobe is seen exactly once.
  always @(negedge clk) begin
    if (rst_n && out_valid && sb != null) begin
      seen = {out_top_angle_raw, out_bottom_angle_raw, out_top_servo_cmd, out_bottom_servo_cmd};
      sb.check_result(seen);
    end
  end

  // Watchdog: any word taken on the setpoint, result or register port resets the count.
  always @(negedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly in-range setpoints; the rest spread over the full 16 bits, cluster around
  // cell boundaries, or sit exactly on the limits.
  function automatic setpoint_t pick_setpoint();
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      v = int'($urandom_range(0, 10240)) - 5120;
    end else if (sel < 75) begin
      v = int'($urandom_range(0, 65535)) - 32768;
    end else if (sel < 90) begin
      v = int'($urandom_range(0, 8)) * 1280 - 5120 + int'($urandom_range(0, 6)) - 3;
    end else begin
      case ($urandom_range(0, 3))
        0: v = 5120;
        1: v = -5120;
        2: v = 32767;
        default: v = -32768;
      endcase
    end
    return setpoint_t'(v);
  endfunction

  // Holds start high until the block takes the word. start is left high so a
  // following word goes back to back; sender_pause or drain_results lowers it.
  task automatic send_setpoint(input setpoint_t pitch, input setpoint_t yaw);
    start             <= 1'b1;
    in_pitch_setpoint <= pitch;
    in_yaw_setpoint   <= yaw;
    do @(negedge clk); while (busy);
    @(posedge clk);
    sb.note_setpoint(pitch, yaw);
  endtask

  task automatic sender_pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // every word returns one result, so an empty queue means the pipe is empty
  task automatic drain_results();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // offsets only change with the pipe empty
  task automatic write_offsets(input offset_t pitch_ofs, input offset_t yaw_ofs);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= gbsm_pkg::REG_PITCH_OFFSET;
    cfg_data  <= pitch_ofs;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    sb.set_offset(gbsm_pkg::REG_PITCH_OFFSET, pitch_ofs);
    cfg_index <= gbsm_pkg::REG_YAW_OFFSET;
    cfg_data  <= yaw_ofs;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    sb.set_offset(gbsm_pkg::REG_YAW_OFFSET, yaw_ofs);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bit last_phase;
    bit calm;
    sb = new();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset offsets
    for (int k = 0; k < N_DIRECTED; k++) begin
      send_setpoint(DIR_PITCH[k], DIR_YAW[k]);
      if (k % 4 == 3) sender_pause($urandom_range(1, 12));
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      // offset settings: reset values, both extremes, past the stated range,
      // mixed, random in range, random over all 16 bits, and back to reset values
      case (phase)
        1: write_offsets(16'd0, 16'd0);
        2: write_offsets(16'd46080, 16'd46080);
        3: write_offsets(16'hFFFF, 16'hFFFF);
        4: write_offsets(16'd46080, 16'd0);
        5: write_offsets(offset_t'($urandom_range(0, 46080)),
                         offset_t'($urandom_range(0, 46080)));
        6: write_offsets(offset_t'($urandom_range(0, 65535)),
                         offset_t'($urandom_range(0, 65535)));
        7: write_offsets(PITCH_OFS_RESET, YAW_OFS_RESET);
        default: ;
      endcase
      last_phase = (phase == N_PHASES - 1);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_setpoint(pick_setpoint(), pick_setpoint());
        // every third stretch of 25 words runs back to back
        calm = ((k / 25) % 3 == 2);
        if ((phase == 3 || phase == 5) && k == ITEMS_PER_PHASE / 2) begin
          // hold the sender until the pipe has emptied out
          drain_results();
        end else if (!last_phase && !calm && $urandom_range(0, 4) == 0) begin
          sender_pause($urandom_range(1, 12));
        end
      end
    end

    drain_results();
    // any late stray strobe shows up in this tail
    repeat (DRAIN_TAIL) @(posedge clk);
    if (sb.failures() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== gimbal_bilinear_servo_map.f =====
rtl/core/gbsm_pkg.sv
rtl/core/gimbal_bilinear_servo_map.sv
tb/gbsm_tb_pkg.sv
tb/gimbal_bilinear_servo_map_tb.sv
